### hdl/lwg_pkg.sv
// Shared widths, register indexes and limits for the level-wind guide controller.
package lwg_pkg;

    // Field and register widths
    localparam int ENC_W      = 32;
    localparam int POS_W      = 16;
    localparam int CORE_W     = 16;
    localparam int THICK_W    = 12;
    localparam int GAIN_W     = 32;
    localparam int LAYER_W    = 10;
    localparam int FRAC_W     = 16;
    localparam int RES_W      = FRAC_W + 1;

    // Datapath widths: |delta| * gain fits in 63 bits, diameter stays below 2^24
    localparam int PROD_W     = ENC_W + GAIN_W;
    localparam int DIAM_W     = 24;
    localparam int MAG_W      = PROD_W - 1;
    localparam int TOGO_W     = MAG_W - FRAC_W;
    localparam int DIV_CNT_W  = $clog2(PROD_W);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_POS   = 3'd0,
        CFG_MIN_POS   = 3'd1,
        CFG_CORE_DIAM = 3'd2,
        CFG_THICKNESS = 3'd3,
        CFG_GAIN      = 3'd4
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam logic [POS_W-1:0]   MAX_POS_RST   = 16'd16000;
    localparam logic [POS_W-1:0]   MIN_POS_RST   = 16'd0;
    localparam logic [CORE_W-1:0]  CORE_DIAM_RST = 16'd10000;
    localparam logic [THICK_W-1:0] THICKNESS_RST = 12'd600;
    localparam logic [GAIN_W-1:0]  GAIN_RST      = 32'd65536;

    // Layer counter saturation
    localparam logic [LAYER_W-1:0] LAYER_MAX = {LAYER_W{1'b1}};

    // Input opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_ZERO   = 1'b1;

endpackage

### hdl/lwg_in_if.sv
// Command channel: opcode and absolute encoder count.
interface lwg_in_if;
    import lwg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic signed [ENC_W-1:0]  encoder_count;

    modport source (output valid, opcode, encoder_count, input ready);
    modport sink   (input valid, opcode, encoder_count, output ready);
endinterface

### hdl/lwg_out_if.sv
// Result channel: one axis target per leg of guide movement.
interface lwg_out_if;
    import lwg_pkg::*;

    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    target_position;
    logic                move_valid;
    logic                heading_right;
    logic [LAYER_W-1:0]  layer_number;
    logic                legs_truncated;
    logic                last;

    modport source (output valid, target_position, move_valid, heading_right,
                    layer_number, legs_truncated, last, input ready);
    modport sink   (input valid, target_position, move_valid, heading_right,
                    layer_number, legs_truncated, last, output ready);
endinterface

### hdl/lwg_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module lwg_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lwg_pkg::PROD_W-1:0]    dividend,
    input  logic [lwg_pkg::DIAM_W-1:0]    divisor,
    output logic                          done,
    output logic [lwg_pkg::PROD_W-1:0]    quotient
);
    import lwg_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIAM_W-1:0]     rem_reg;
    logic [DIAM_W-1:0]     divisor_reg;
    logic [PROD_W-1:0]     quo_reg;

    logic [DIAM_W:0]       trial;
    logic [DIAM_W:0]       diff;
    logic                  fits;

    // One trial subtraction per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[PROD_W-1]};
        diff  = trial - {1'b0, divisor_reg};
        fits  = (trial >= {1'b0, divisor_reg});
    end

    // Sequencing: count the quotient bits, pulse done on the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(PROD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIAM_W-1:0] : trial[DIAM_W-1:0];
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // Remainder stays below the divisor through the whole run
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < divisor_reg))
        else $error("divider remainder reached divisor");

    // A start always begins a run
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");

    // Done ends the run
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider busy after done");

endmodule

### hdl/level_wind_guide_controller_core.sv
// Level-wind guide controller: encoder counts in, guide axis targets out.
//
//  channel | dir | handshake     | payload
//  cmd     | in  | valid/ready   | opcode, encoder_count
//  leg     | out | valid/ready   | target_position, move_valid, heading_right,
//          |     |               | layer_number, legs_truncated, last
//  cfg     | in  | cfg_we        | cfg_index, cfg_data (no read-back)
//
//  An encoder sample runs through the serial divider, which produces one
//  quotient bit per cycle; a zero command skips the divider. One item is in
//  flight at a time; cmd.ready is high only when idle. Each leg waits in the
//  output register until taken, so a stall on the leg channel holds the leg
//  sequencer. Reset restores the register defaults and clears the tracking
//  state; there is no clearing pass.
module level_wind_guide_controller_core #(
    parameter int MAX_LEGS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lwg_in_if.sink                          cmd,
    lwg_out_if.source                       leg,
    input  logic                            cfg_we,
    input  logic [lwg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lwg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lwg_pkg::*;

    localparam int LEG_W = (MAX_LEGS > 2) ? $clog2(MAX_LEGS) : 1;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_PREP   = 8'b0000_0010,
        ST_DSTART = 8'b0000_0100,
        ST_DWAIT  = 8'b0000_1000,
        ST_SUM    = 8'b0001_0000,
        ST_DECIDE = 8'b0010_0000,
        ST_LEG    = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } state_t;

    // Configuration registers
    logic [POS_W-1:0]    max_pos_reg;
    logic [POS_W-1:0]    min_pos_reg;
    logic [CORE_W-1:0]   core_diam_reg;
    logic [THICK_W-1:0]  thickness_reg;
    logic [GAIN_W-1:0]   gain_reg;

    // Tracking state
    state_t                     state_reg;
    logic [ENC_W-1:0]           prev_count_reg;
    logic signed [RES_W-1:0]    residue_reg;
    logic [POS_W-1:0]           axis_reg;
    logic                       moving_right_reg;
    logic [LAYER_W-1:0]         layer_reg;
    logic [LEG_W-1:0]           legs_reg;
    logic                       dir_reg;

    // Per-item working registers
    logic                       op_reg;
    logic [ENC_W-1:0]           enc_reg;
    logic [ENC_W-1:0]           delta_reg;
    logic [PROD_W-1:0]          product_reg;
    logic [DIAM_W-1:0]          diam_reg;
    logic signed [PROD_W-1:0]   exact_reg;
    logic [TOGO_W-1:0]          togo_reg;
    logic                       neg_reg;

    // Output register
    logic                  out_valid_reg;
    logic [POS_W-1:0]      out_target_reg;
    logic                  out_move_reg;
    logic                  out_heading_reg;
    logic [LAYER_W-1:0]    out_layer_reg;
    logic                  out_trunc_reg;
    logic                  out_last_reg;

    logic                  div_start;
    logic                  div_done;
    logic [PROD_W-1:0]     div_quotient;

    logic                  cmd_xfer;
    logic                  out_free;
    logic                  out_load;

    // Prep arithmetic
    logic                          dneg;
    logic [ENC_W-1:0]              dmag;
    logic [THICK_W+LAYER_W-1:0]    thick_layer;
    logic [DIAM_W-1:0]             diam_sum;

    // Accumulate / decide arithmetic
    logic signed [PROD_W-1:0]      res_ext;
    logic signed [PROD_W-1:0]      q_ext;
    logic                          exact_neg;
    logic [PROD_W-1:0]             exact_abs;
    logic [TOGO_W-1:0]             togo_new;
    logic [FRAC_W-1:0]             frac_new;
    logic                          will_move;

    // Leg arithmetic
    logic [POS_W-1:0]      rem_room;
    logic                  reverse;
    logic [POS_W-1:0]      axis_after;
    logic                  dir_after;
    logic [TOGO_W-1:0]     togo_after;
    logic [LAYER_W-1:0]    layer_after;
    logic                  leg_last;

    // Single-result payloads for the zero command and the no-move case
    logic [POS_W-1:0]      emit_target;
    logic                  emit_move;
    logic                  emit_heading;
    logic [LAYER_W-1:0]    emit_layer;

    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || leg.ready;
    assign div_start = (state_reg == ST_DSTART);
    assign out_load  = out_free && ((state_reg == ST_LEG) || (state_reg == ST_EMIT));

    // Shared serial divider: |delta| * gain / diameter
    lwg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product_reg),
        .divisor  (diam_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Count change magnitude and present reel diameter
    always_comb
    begin
        dneg        = delta_reg[ENC_W-1];
        dmag        = dneg ? (ENC_W'(0) - delta_reg) : delta_reg;
        thick_layer = (THICK_W+LAYER_W)'(thickness_reg) * (THICK_W+LAYER_W)'(layer_reg);
        diam_sum    = DIAM_W'(core_diam_reg) + DIAM_W'({thick_layer, 1'b0});
    end

    // Signed travel in Q16 plus kept residue, then magnitude split
    always_comb
    begin
        res_ext   = PROD_W'(residue_reg);
        q_ext     = $signed({1'b0, div_quotient[MAG_W-1:0]});
        exact_neg = exact_reg[PROD_W-1];
        exact_abs = exact_neg ? (PROD_W'(0) - exact_reg) : exact_reg;
        togo_new  = exact_abs[MAG_W-1:FRAC_W];
        frac_new  = exact_abs[FRAC_W-1:0];
        will_move = |togo_new[TOGO_W-1:1];
    end

    // One leg: run toward the limit in the current direction
    always_comb
    begin
        if (dir_reg)
            rem_room = (axis_reg < max_pos_reg) ? (max_pos_reg - axis_reg) : '0;
        else
            rem_room = (axis_reg > min_pos_reg) ? (axis_reg - min_pos_reg) : '0;
        reverse = (togo_reg > TOGO_W'(rem_room));
        if (reverse)
        begin
            axis_after = dir_reg ? max_pos_reg : min_pos_reg;
            dir_after  = !dir_reg;
            togo_after = togo_reg - TOGO_W'(rem_room);
            if (neg_reg)
                layer_after = (layer_reg != '0) ? (layer_reg - 1'b1) : layer_reg;
            else
                layer_after = (layer_reg != LAYER_MAX) ? (layer_reg + 1'b1) : layer_reg;
        end
        else
        begin
            axis_after  = dir_reg ? (axis_reg + togo_reg[POS_W-1:0])
                                  : (axis_reg - togo_reg[POS_W-1:0]);
            dir_after   = dir_reg;
            togo_after  = '0;
            layer_after = layer_reg;
        end
        leg_last = (togo_after == '0) || (legs_reg == LEG_W'(MAX_LEGS - 1));
    end

    // Zero command reports the home position; otherwise the held position
    always_comb
    begin
        if (op_reg == OP_ZERO)
        begin
            emit_target  = '0;
            emit_move    = 1'b1;
            emit_heading = 1'b1;
            emit_layer   = '0;
        end
        else
        begin
            emit_target  = axis_reg;
            emit_move    = 1'b0;
            emit_heading = moving_right_reg;
            emit_layer   = layer_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pos_reg   <= MAX_POS_RST;
            min_pos_reg   <= MIN_POS_RST;
            core_diam_reg <= CORE_DIAM_RST;
            thickness_reg <= THICKNESS_RST;
            gain_reg      <= GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MAX_POS:   max_pos_reg   <= cfg_data[POS_W-1:0];
                CFG_MIN_POS:   min_pos_reg   <= cfg_data[POS_W-1:0];
                CFG_CORE_DIAM: core_diam_reg <= cfg_data[CORE_W-1:0];
                CFG_THICKNESS: thickness_reg <= cfg_data[THICK_W-1:0];
                CFG_GAIN:      gain_reg      <= cfg_data[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // Sequencer and tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            prev_count_reg   <= '0;
            residue_reg      <= '0;
            axis_reg         <= '0;
            moving_right_reg <= 1'b1;
            layer_reg        <= '0;
            legs_reg         <= '0;
            dir_reg          <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_xfer)
                        state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    state_reg <= (op_reg == OP_ZERO) ? ST_EMIT : ST_DSTART;
                end
                ST_DSTART:
                begin
                    state_reg <= ST_DWAIT;
                end
                ST_DWAIT:
                begin
                    if (div_done)
                        state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    if (will_move)
                    begin
                        residue_reg    <= exact_neg ? -$signed({1'b0, frac_new})
                                                    :  $signed({1'b0, frac_new});
                        prev_count_reg <= enc_reg;
                        dir_reg        <= moving_right_reg ^ exact_neg;
                        legs_reg       <= '0;
                        state_reg      <= ST_LEG;
                    end
                    else
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_LEG:
                begin
                    if (out_free)
                    begin
                        axis_reg         <= axis_after;
                        dir_reg          <= dir_after;
                        layer_reg        <= layer_after;
                        moving_right_reg <= dir_after ^ neg_reg;
                        legs_reg         <= legs_reg + 1'b1;
                        if (leg_last)
                            state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        if (op_reg == OP_ZERO)
                        begin
                            prev_count_reg   <= enc_reg;
                            residue_reg      <= '0;
                            axis_reg         <= '0;
                            layer_reg        <= '0;
                            moving_right_reg <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Working registers for the item in flight
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            op_reg    <= cmd.opcode;
            enc_reg   <= cmd.encoder_count;
            delta_reg <= cmd.encoder_count - prev_count_reg;
        end
        if (state_reg == ST_PREP)
        begin
            product_reg <= PROD_W'(dmag) * PROD_W'(gain_reg);
            diam_reg    <= (diam_sum == '0) ? DIAM_W'(1) : diam_sum;
        end
        if (state_reg == ST_SUM)
            exact_reg <= dneg ? (res_ext - q_ext) : (res_ext + q_ext);
        if (state_reg == ST_DECIDE)
        begin
            togo_reg <= togo_new;
            neg_reg  <= exact_neg;
        end
        else if ((state_reg == ST_LEG) && out_free)
        begin
            togo_reg <= togo_after;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (leg.ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (state_reg == ST_LEG)
            begin
                out_target_reg  <= axis_after;
                out_move_reg    <= 1'b1;
                out_heading_reg <= dir_after ^ neg_reg;
                out_layer_reg   <= layer_after;
                out_trunc_reg   <= leg_last && (togo_after != '0);
                out_last_reg    <= leg_last;
            end
            else
            begin
                out_target_reg  <= emit_target;
                out_move_reg    <= emit_move;
                out_heading_reg <= emit_heading;
                out_layer_reg   <= emit_layer;
                out_trunc_reg   <= 1'b0;
                out_last_reg    <= 1'b1;
            end
        end
    end

    assign leg.valid           = out_valid_reg;
    assign leg.target_position = out_target_reg;
    assign leg.move_valid      = out_move_reg;
    assign leg.heading_right   = out_heading_reg;
    assign leg.layer_number    = out_layer_reg;
    assign leg.legs_truncated  = out_trunc_reg;
    assign leg.last            = out_last_reg;

    // Divider only finishes while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DWAIT))
        else $error("divider done outside wait state");

    // Every leg has travel left to cover
    a_leg_has_travel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEG) |-> (togo_reg != '0))
        else $error("leg state with no travel left");

    // Residue magnitude stays below one whole step
    a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
        residue_reg != $signed({1'b1, {(RES_W-1){1'b0}}}))
        else $error("step residue reached a whole step");

    // A transfer on cmd starts the sequencer
    a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |=> (state_reg == ST_PREP))
        else $error("command transfer did not start sequencer");

endmodule

### tb/sv/lwg_guide_checker.sv
// Level-wind guide checker: watches the command, leg and register ports and checks each leg.
module lwg_guide_checker #(
    parameter int MAX_LEGS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lwg_in_if                               cmd,
    lwg_out_if                              leg,
    input  logic                            cfg_we,
    input  logic [lwg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lwg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatch_count,
    output int                              legs_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import lwg_pkg::*;

    // One leg as it appears on the output channel
    typedef struct packed {
        logic [POS_W-1:0]   target;
        logic               move_valid;
        logic               heading_right;
        logic [LAYER_W-1:0] layer;
        logic               truncated;
        logic               last;
    } leg_t;

    // Register copies
    logic [POS_W-1:0]   right_limit;
    logic [POS_W-1:0]   left_limit;
    logic [CORE_W-1:0]  core_diam;
    logic [THICK_W-1:0] thickness;
    logic [GAIN_W-1:0]  gain;

    // Tracking state of the guide
    logic [ENC_W-1:0]   anchor_count;
    int                 residue;
    logic [POS_W-1:0]   axis;
    logic               heading;
    logic [LAYER_W-1:0] layers;

    leg_t legs_due[$];

    // Work out the legs that one command causes and queue them
    task automatic predict_legs(input logic op, input logic [ENC_W-1:0] enc);
        logic [ENC_W-1:0] delta;
        logic [ENC_W-1:0] count_mag;
        logic [31:0]      diam;
        logic [63:0]      quo;
        logic [63:0]      emag;
        logic [63:0]      togo;
        logic [63:0]      room;
        longint           travel;
        logic             neg;
        logic             dir;
        logic             turn;
        leg_t             r;
        int               n;
        if (op == OP_ZERO)
        begin
            anchor_count = enc;
            residue      = 0;
            axis         = '0;
            layers       = '0;
            heading      = 1'b1;
            legs_due.push_back({POS_W'(0), 1'b1, 1'b1, LAYER_W'(0), 1'b0, 1'b1});
            return;
        end

        // Signed Q16 travel from the count change, plus the kept residue
        delta     = enc - anchor_count;
        count_mag = delta[ENC_W-1] ? -delta : delta;
        diam      = core_diam + 32'd2 * thickness * layers;
        if (diam == 0)
            diam = 1;
        quo    = {32'd0, count_mag} * gain / diam;
        travel = delta[ENC_W-1] ? -longint'(quo) : longint'(quo);
        travel = travel + residue;
        neg    = travel < 0;
        emag   = neg ? -travel : travel;
        togo   = emag >> FRAC_W;

        // At most one whole step: report the position, keep all state
        if (togo <= 1)
        begin
            legs_due.push_back({axis, 1'b0, heading, layers, 1'b0, 1'b1});
            return;
        end

        residue = neg ? -int'(emag[FRAC_W-1:0]) : int'(emag[FRAC_W-1:0]);
        anchor_count = enc;
        dir = neg ? !heading : heading;
        n = 0;

        // Bounce between the limits, one leg per stretch
        while (togo != 0 && n < MAX_LEGS)
        begin
            if (dir)
            begin
                room = (axis < right_limit) ? right_limit - axis : 0;
                turn = togo > room;
                if (turn)
                begin
                    axis = right_limit;
                    dir  = 1'b0;
                end
                else
                    axis = axis + togo[POS_W-1:0];
            end
            else
            begin
                room = (axis > left_limit) ? axis - left_limit : 0;
                turn = togo > room;
                if (turn)
                begin
                    axis = left_limit;
                    dir  = 1'b1;
                end
                else
                    axis = axis - togo[POS_W-1:0];
            end
            if (turn)
            begin
                togo = togo - room;
                if (neg)
                begin
                    if (layers != 0)
                        layers = layers - 1'b1;
                end
                else if (layers != LAYER_MAX)
                    layers = layers + 1'b1;
            end
            else
                togo = 0;
            legs_due.push_back({axis, 1'b1, (neg ? !dir : dir), layers, 1'b0, 1'b0});
            n++;
        end
        heading = neg ? !dir : dir;

        // Final leg carries last and the cut-short flag
        r = legs_due.pop_back();
        r.truncated = (togo != 0);
        r.last      = 1'b1;
        legs_due.push_back(r);
    endtask

    // Compare legs, follow register writes, predict on each command transfer
    always @(posedge clk or negedge rst_n)
    begin
        leg_t got;
        leg_t want;
        if (!rst_n)
        begin
            right_limit    = MAX_POS_RST;
            left_limit     = MIN_POS_RST;
            core_diam      = CORE_DIAM_RST;
            thickness      = THICKNESS_RST;
            gain           = GAIN_RST;
            anchor_count   = '0;
            residue        = 0;
            axis           = '0;
            heading        = 1'b1;
            layers         = '0;
            mismatch_count = 0;
            legs_due.delete();
        end
        else
        begin
            if (leg.valid && leg.ready)
            begin
                got = {leg.target_position, leg.move_valid, leg.heading_right,
                       leg.layer_number, leg.legs_truncated, leg.last};
                if (legs_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: leg with none due: target %0d move %0b head %0b",
                                 $time, got.target, got.move_valid, got.heading_right,
                                 " layer %0d trunc %0b last %0b",
                                 got.layer, got.truncated, got.last);
                end
                else
                begin
                    want = legs_due.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: leg mismatch: want target %0d move %0b head %0b",
                                     $time, want.target, want.move_valid,
                                     want.heading_right,
                                     " layer %0d trunc %0b last %0b; got target %0d",
                                     want.layer, want.truncated, want.last, got.target,
                                     " move %0b head %0b layer %0d trunc %0b last %0b",
                                     got.move_valid, got.heading_right, got.layer,
                                     got.truncated, got.last);
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_POS:   right_limit = cfg_data[POS_W-1:0];
                    CFG_MIN_POS:   left_limit  = cfg_data[POS_W-1:0];
                    CFG_CORE_DIAM: core_diam   = cfg_data[CORE_W-1:0];
                    CFG_THICKNESS: thickness   = cfg_data[THICK_W-1:0];
                    CFG_GAIN:      gain        = cfg_data[GAIN_W-1:0];
                    default:       ;
                endcase
            end

            if (cmd.valid && cmd.ready)
                predict_legs(cmd.opcode, cmd.encoder_count);
        end
        legs_outstanding = legs_due.size();
    end

endmodule

### tb/sv/tb.sv
// Testbench top for the level-wind guide controller: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lwg_pkg::*;

    localparam int LEG_LIMIT    = 8;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 30;
    localparam int SWEEP_ITEMS  = 140;
    localparam int SWEEP_BACK   = 8;
    localparam int DRAIN_CYCLES = 100;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatch_count;
    int                    legs_outstanding;
    bit                    calm;
    logic [ENC_W-1:0]      last_enc;

    lwg_in_if  cmd_ch();
    lwg_out_if leg_ch();

    level_wind_guide_controller_core #(
        .MAX_LEGS (LEG_LIMIT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .leg       (leg_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lwg_guide_checker #(
        .MAX_LEGS (LEG_LIMIT)
    ) i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd_ch),
        .leg              (leg_ch),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .legs_outstanding (legs_outstanding)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Idle cycles before the next transfer on either side
    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // Register write, one cycle of write enable
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Drop valid and wait until every due leg has come out
    task automatic wait_idle();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (legs_outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One command transfer after a random gap
    task automatic send_cmd(input logic op, input logic [ENC_W-1:0] enc);
        int gap;
        gap = draw_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.opcode        <= op;
        cmd_ch.encoder_count <= enc;
        last_enc = enc;
        do
            @(posedge clk);
        while (!(cmd_ch.valid && cmd_ch.ready));
    endtask

    // Leg receiver with random stalls
    initial
    begin
        int stall;
        leg_ch.ready = 1'b0;
        forever
        begin
            stall = draw_wait();
            @(negedge clk);
            if (stall > 0)
            begin
                leg_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            leg_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(leg_ch.valid && leg_ch.ready));
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [POS_W-1:0]   minp;
        logic [POS_W-1:0]   maxp;
        logic [CORE_W-1:0]  core;
        logic [THICK_W-1:0] thick;
        logic [GAIN_W-1:0]  gain;
        longint             core_eff;
        longint             scale;
        longint             want;
        longint             counts;
        int                 span;
        int                 kind;
        int                 whole;

        cmd_ch.valid         = 1'b0;
        cmd_ch.opcode        = OP_SAMPLE;
        cmd_ch.encoder_count = '0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_MAX_POS;
        cfg_data             = '0;
        calm                 = 1'b0;
        last_enc             = '0;
        rst_n                = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: one step per 10000 counts
        send_cmd(OP_SAMPLE, 32'd0);             // no change
        send_cmd(OP_SAMPLE, 32'd15000);         // 1.5 steps, held back
        send_cmd(OP_SAMPLE, 32'd25000);         // 2.5 steps, residue kept
        send_cmd(OP_SAMPLE, 32'd40000);         // residue completes a step
        send_cmd(OP_SAMPLE, 32'd30000);         // -1 step, no move
        send_cmd(OP_SAMPLE, 32'd10000);         // backward travel
        send_cmd(OP_SAMPLE, -32'sd80000);       // backward past the left limit, layer floor
        send_cmd(OP_SAMPLE, 32'h7FFF_FFFF);     // huge travel, legs cut short
        send_cmd(OP_SAMPLE, 32'h8000_0000);     // count wraps to a delta of one
        send_cmd(OP_SAMPLE, 32'hFFFF_FFFF);     // most negative delta
        send_cmd(OP_ZERO, 32'h8000_0000);
        send_cmd(OP_ZERO, 32'h7FFF_FFFF);

        // Register extremes
        wait_idle();
        write_reg(CFG_GAIN, 32'hFFFF_FFFF);
        write_reg(CFG_CORE_DIAM, 32'h0000_FFFF);
        write_reg(CFG_THICKNESS, 32'h0000_0FFF);
        write_reg(CFG_MAX_POS, 32'h0000_FFFF);
        write_reg(CFG_MIN_POS, 32'h0000_0000);
        send_cmd(OP_SAMPLE, 32'hFFFF_FFFE);
        send_cmd(OP_SAMPLE, 32'h7FFF_FFFE);

        // Zero diameter, position left of the left limit
        wait_idle();
        write_reg(CFG_CORE_DIAM, 32'd0);
        write_reg(CFG_THICKNESS, 32'd0);
        write_reg(CFG_GAIN, 32'd3 << 16);
        write_reg(CFG_MAX_POS, 32'd100);
        write_reg(CFG_MIN_POS, 32'd20);
        send_cmd(OP_ZERO, 32'd0);
        send_cmd(OP_SAMPLE, 32'd1);
        send_cmd(OP_SAMPLE, 32'd0);

        // Left limit above the right limit
        wait_idle();
        write_reg(CFG_MIN_POS, 32'd200);
        write_reg(CFG_GAIN, 32'd5 << 16);
        send_cmd(OP_SAMPLE, 32'd100);

        // Zero gain
        wait_idle();
        write_reg(CFG_GAIN, 32'd0);
        send_cmd(OP_SAMPLE, 32'h1234_5678);

        // Limits equal
        wait_idle();
        write_reg(CFG_MIN_POS, 32'd50);
        write_reg(CFG_MAX_POS, 32'd50);
        write_reg(CFG_GAIN, 32'd2 << 16);
        send_cmd(OP_SAMPLE, 32'd105);

        // Indexes past the last register are ignored
        wait_idle();
        for (int k = 1; k <= 3; k++)
            write_reg(CFG_IDX_W'(CFG_GAIN + k), $urandom());
        send_cmd(OP_SAMPLE, 32'd110);
        send_cmd(OP_ZERO, 32'd0);

        // Random phases, each with its own settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            calm = ($urandom_range(0, 3) == 0);
            if (ph == 0)
            begin
                minp = '0;
                maxp = '1;
            end
            else
            begin
                minp = POS_W'($urandom_range(0, 3000));
                maxp = POS_W'(minp + $urandom_range(0, 1500));
                if ($urandom_range(0, 7) == 0)
                    {minp, maxp} = {maxp, minp};
            end
            core  = (ph == 1) ? '0 : CORE_W'($urandom_range(1, 65535));
            thick = ($urandom_range(0, 5) == 0) ? THICK_W'($urandom_range(0, 4095))
                                                : THICK_W'($urandom_range(0, 200));
            core_eff = (core == 0) ? 1 : longint'(core);
            if ($urandom_range(0, 5) == 0)
            begin
                gain  = $urandom();
                scale = longint'(gain) / core_eff;
                if (scale == 0)
                    scale = 1;
            end
            else
            begin
                scale = $urandom_range(4096, 65536);
                gain  = GAIN_W'(core_eff * scale);
            end
            span = ((maxp >= minp) ? int'(maxp - minp) : int'(minp - maxp)) + 1;
            write_reg(CFG_MAX_POS, {16'($urandom()), maxp});
            write_reg(CFG_MIN_POS, {16'($urandom()), minp});
            write_reg(CFG_CORE_DIAM, {16'($urandom()), core});
            write_reg(CFG_THICKNESS, {20'($urandom()), thick});
            write_reg(CFG_GAIN, gain);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                kind = $urandom_range(0, 19);
                if (kind == 0)
                    send_cmd(OP_ZERO, $urandom());
                else if (kind <= 2)
                    send_cmd(OP_SAMPLE, $urandom());
                else
                begin
                    // Pick the travel in steps, then the count change that gives it
                    if (kind <= 7)
                        whole = $urandom_range(0, 2);
                    else if (kind <= 16)
                        whole = $urandom_range(2, 3 * span);
                    else
                        whole = $urandom_range(20 * span, 40 * span);
                    want   = (longint'(whole) << 16) + $urandom_range(0, 65535);
                    counts = want / scale;
                    if (counts > 64'sh7FFF_FFFF)
                        counts = 64'sh7FFF_FFFF;
                    if ($urandom_range(0, 2) == 0)
                        counts = -counts;
                    send_cmd(OP_SAMPLE, last_enc + ENC_W'(counts));
                end
            end
        end

        // Zero-width travel range: every leg turns, layers run up to saturation
        wait_idle();
        calm = 1'b0;
        core = CORE_W'($urandom_range(1, 65535));
        minp = POS_W'($urandom_range(0, 65535));
        write_reg(CFG_THICKNESS, 32'd0);
        write_reg(CFG_CORE_DIAM, {16'd0, core});
        write_reg(CFG_GAIN, {core, 16'd0});
        write_reg(CFG_MIN_POS, {16'd0, minp});
        write_reg(CFG_MAX_POS, {16'd0, minp});
        for (int n = 0; n < SWEEP_ITEMS; n++)
        begin
            if (n < SWEEP_ITEMS - SWEEP_BACK)
                send_cmd(OP_SAMPLE, last_enc + ENC_W'($urandom_range(3, 60)));
            else
                send_cmd(OP_SAMPLE, last_enc - ENC_W'($urandom_range(3, 60)));
        end
        send_cmd(OP_ZERO, $urandom());

        // Drain and report
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && legs_outstanding == 0)
            $display("level_wind_guide_controller_core regression: pass");
        else
            $display("level_wind_guide_controller_core regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("level_wind_guide_controller_core regression: fail");
        $finish;
    end

endmodule
